// ===== rtl/ethernet_rx_arp_classifier_top_defines.svh =====
// Assertion helpers for the checker file of the receive classifier.
`ifndef ETHERNET_RX_ARP_CLASSIFIER_TOP_DEFINES_SVH
`define ETHERNET_RX_ARP_CLASSIFIER_TOP_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define ERAC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising clock edge, reset included.
`define ERAC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/erac_pkg.sv =====
package erac_pkg;

	localparam int CNT_W     = 6;
	localparam int COUNT_MAX = 63;
	localparam int MAC_W     = 48;
	localparam int IP_W      = 32;
	localparam int VLAN_W    = 12;

	// Frame lengths needed before a header may be trusted.
	localparam int ETH_HDR_LEN  = 14;
	localparam int VLAN_END_LEN = 18;
	localparam int ARP_END_LEN  = 42;

	// Byte offsets of the captured header fields.
	localparam int OFS_DST   = 0;
	localparam int OFS_ETYPE = 12;
	localparam int OFS_W14   = 14;
	localparam int OFS_PTYPE = 16;
	localparam int OFS_HLEN  = 18;
	localparam int OFS_OPER  = 20;
	localparam int OFS_SHA   = 22;
	localparam int OFS_SPA   = 28;
	localparam int OFS_TPA   = 38;

	localparam logic [15:0]      ETYPE_IPV4     = 16'h0800;
	localparam logic [15:0]      ETYPE_ARP      = 16'h0806;
	localparam logic [15:0]      ETYPE_VLAN     = 16'h8100;
	localparam logic [15:0]      ARP_HTYPE_ETH  = 16'h0001;
	localparam logic [7:0]       ARP_HLEN_ETH   = 8'h06;
	localparam logic [15:0]      ARP_OP_REQUEST = 16'h0001;
	localparam logic [15:0]      ARP_OP_REPLY   = 16'h0002;
	localparam logic [MAC_W-1:0] BCAST_MAC      = 48'hffff_ffff_ffff;

	typedef enum logic [3:0] {
		VERDICT_NOT_FOR_ME     = 4'd0,
		VERDICT_MALFORMED      = 4'd1,
		VERDICT_IPV4           = 4'd2,
		VERDICT_VLAN           = 4'd3,
		VERDICT_ARP_REQ_REPLY  = 4'd4,
		VERDICT_ARP_REQ_OTHER  = 4'd5,
		VERDICT_ARP_REP_UPDATE = 4'd6,
		VERDICT_ARP_REP_OTHER  = 4'd7,
		VERDICT_OTHER_DROPPED  = 4'd8
	} verdict_t;

	typedef enum logic [0:0] {
		CFG_OWN_MAC = 1'b0,
		CFG_OWN_IP  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [MAC_W-1:0] dst;
		logic [15:0]      etype;
		logic [15:0]      word14;
		logic [15:0]      ptype;
		logic [7:0]       hlen;
		logic [15:0]      oper;
		logic [MAC_W-1:0] sha;
		logic [IP_W-1:0]  spa;
		logic [IP_W-1:0]  tpa;
	} hdr_fields_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [VLAN_W-1:0] vlan_id;
		logic [MAC_W-1:0]  peer_mac;
		logic [IP_W-1:0]   peer_ip;
	} result_t;

endpackage

// ===== rtl/erac_byte_if.sv =====
interface erac_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/erac_verdict_if.sv =====
interface erac_verdict_if;
	import erac_pkg::*;

	logic              valid;
	logic              ready;
	verdict_t          verdict;
	logic [VLAN_W-1:0] vlan_id;
	logic [MAC_W-1:0]  peer_mac;
	logic [IP_W-1:0]   peer_ip;

	modport source (output valid, output verdict, output vlan_id, output peer_mac,
		output peer_ip, input ready);
	modport sink (input valid, input verdict, input vlan_id, input peer_mac,
		input peer_ip, output ready);
endinterface

// ===== rtl/ethernet_rx_arp_classifier_top.sv =====
// Ethernet receive classifier with ARP check.
// rx carries one frame byte per beat in wire order; last_byte marks the
// final beat of a frame. res carries one verdict beat per frame, with the
// VLAN id or the ARP sender MAC and IP where the verdict calls for them.
// Header fields are captured into dedicated registers as their bytes pass,
// so a new byte is accepted every cycle while rx.ready is high, and frames
// may follow back to back. The verdict of a frame goes through the capture
// stage, then the result register, to res, one verdict per frame. The decision
// between the capture registers and the result register is combinational.
// When res stalls, bytes keep flowing while the capture stage holds no
// verdict; rx.ready drops only while a finished verdict waits in the
// capture stage behind a full result register that is not being taken.
// Reset clears the byte count, the pending verdict, the result valid and
// both station addresses. The user writes addresses through cfg_we, cfg_index
// and cfg_data only while no frame is in flight; the block does not enforce it.
module ethernet_rx_arp_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  erac_pkg::cfg_idx_t            cfg_index,
	input  logic [erac_pkg::MAC_W-1:0]    cfg_data,
	erac_byte_if.sink                     rx,
	erac_verdict_if.source                res
);
	import erac_pkg::*;

	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  own_ip_q;
	logic             accept;
	logic             can_load;
	logic             advance;
	logic             pending_s1;
	logic [CNT_W-1:0] len_s1;
	hdr_fields_t      hdr_s1;
	result_t          result;
	result_t          res_q;
	logic             res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_MAC: own_mac_q <= cfg_data;
				CFG_OWN_IP:  own_ip_q  <= cfg_data[IP_W-1:0];
			endcase
		end
	end

	assign can_load = !res_valid_q || res.ready;
	assign advance  = pending_s1 && can_load;
	assign rx.ready = !pending_s1 || can_load;
	assign accept   = rx.valid && rx.ready;

	erac_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (rx.frame_byte),
		.last_byte  (rx.last_byte),
		.advance    (advance),
		.pending_s1 (pending_s1),
		.len_s1     (len_s1),
		.hdr_s1     (hdr_s1)
	);

	erac_classify u_classify (
		.hdr     (hdr_s1),
		.len     (len_s1),
		.own_mac (own_mac_q),
		.own_ip  (own_ip_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_load) begin
			res_valid_q <= pending_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.verdict  = res_q.verdict;
	assign res.vlan_id  = res_q.vlan_id;
	assign res.peer_mac = res_q.peer_mac;
	assign res.peer_ip  = res_q.peer_ip;

endmodule

// ===== rtl/erac_capture.sv =====
module erac_capture (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   frame_byte,
	input  logic                         last_byte,
	input  logic                         advance,
	output logic                         pending_s1,
	output logic [erac_pkg::CNT_W-1:0]   len_s1,
	output erac_pkg::hdr_fields_t        hdr_s1
);
	import erac_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] len_next;

	function automatic logic in_span(input logic [CNT_W-1:0] c, input int lo, input int n);
		in_span = (int'(c) >= lo) && (int'(c) < lo + n);
	endfunction

	assign len_next = (cnt_q == CNT_W'(COUNT_MAX)) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pending_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= last_byte ? '0 : len_next;
			end
			if (accept && last_byte) begin
				pending_s1 <= 1'b1;
			end else if (advance) begin
				pending_s1 <= 1'b0;
			end
		end
	end

	// Bytes arrive in order, so each field is shifted in while the count
	// walks across its span; bytes outside every span are dropped.
	always_ff @(posedge clk) begin
		if (accept) begin
			len_s1 <= len_next;
			if (in_span(cnt_q, OFS_DST, 6))
				hdr_s1.dst <= {hdr_s1.dst[MAC_W-9:0], frame_byte};
			if (in_span(cnt_q, OFS_ETYPE, 2))
				hdr_s1.etype <= {hdr_s1.etype[7:0], frame_byte};
			if (in_span(cnt_q, OFS_W14, 2))
				hdr_s1.word14 <= {hdr_s1.word14[7:0], frame_byte};
			if (in_span(cnt_q, OFS_PTYPE, 2))
				hdr_s1.ptype <= {hdr_s1.ptype[7:0], frame_byte};
			if (in_span(cnt_q, OFS_HLEN, 1))
				hdr_s1.hlen <= frame_byte;
			if (in_span(cnt_q, OFS_OPER, 2))
				hdr_s1.oper <= {hdr_s1.oper[7:0], frame_byte};
			if (in_span(cnt_q, OFS_SHA, 6))
				hdr_s1.sha <= {hdr_s1.sha[MAC_W-9:0], frame_byte};
			if (in_span(cnt_q, OFS_SPA, 4))
				hdr_s1.spa <= {hdr_s1.spa[IP_W-9:0], frame_byte};
			if (in_span(cnt_q, OFS_TPA, 4))
				hdr_s1.tpa <= {hdr_s1.tpa[IP_W-9:0], frame_byte};
		end
	end

endmodule

// ===== rtl/erac_classify.sv =====
module erac_classify (
	input  erac_pkg::hdr_fields_t          hdr,
	input  logic [erac_pkg::CNT_W-1:0]     len,
	input  logic [erac_pkg::MAC_W-1:0]     own_mac,
	input  logic [erac_pkg::IP_W-1:0]      own_ip,
	output erac_pkg::result_t              result
);
	import erac_pkg::*;

	logic dst_ok;
	logic to_me;
	logic arp_hdr_ok;

	assign dst_ok     = (hdr.dst == own_mac) || (hdr.dst == BCAST_MAC);
	assign to_me      = (hdr.tpa == own_ip);
	// The protocol address length byte is deliberately not checked.
	assign arp_hdr_ok = (int'(len) >= ARP_END_LEN) && (hdr.word14 == ARP_HTYPE_ETH) &&
		(hdr.ptype == ETYPE_IPV4) && (hdr.hlen == ARP_HLEN_ETH);

	always_comb begin
		result         = '0;
		result.verdict = VERDICT_NOT_FOR_ME;
		if (int'(len) < ETH_HDR_LEN) begin
			result.verdict = VERDICT_MALFORMED;
		end else if (!dst_ok) begin
			result.verdict = VERDICT_NOT_FOR_ME;
		end else begin
			case (hdr.etype)
				ETYPE_VLAN: begin
					if (int'(len) < VLAN_END_LEN) begin
						result.verdict = VERDICT_MALFORMED;
					end else begin
						result.verdict = VERDICT_VLAN;
						result.vlan_id = hdr.word14[VLAN_W-1:0];
					end
				end
				ETYPE_IPV4: begin
					result.verdict = VERDICT_IPV4;
				end
				ETYPE_ARP: begin
					if (arp_hdr_ok && hdr.oper == ARP_OP_REQUEST) begin
						result.verdict  = to_me ? VERDICT_ARP_REQ_REPLY : VERDICT_ARP_REQ_OTHER;
						result.peer_mac = hdr.sha;
						result.peer_ip  = hdr.spa;
					end else if (arp_hdr_ok && hdr.oper == ARP_OP_REPLY) begin
						result.verdict  = to_me ? VERDICT_ARP_REP_UPDATE : VERDICT_ARP_REP_OTHER;
						result.peer_mac = hdr.sha;
						result.peer_ip  = hdr.spa;
					end else begin
						result.verdict = VERDICT_MALFORMED;
					end
				end
				default: begin
					result.verdict = VERDICT_OTHER_DROPPED;
				end
			endcase
		end
	end

endmodule

// ===== rtl/erac_checker.sv =====
`include "ethernet_rx_arp_classifier_top_defines.svh"

module erac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rx_valid,
	input logic                        rx_ready,
	input logic                        rx_last_byte,
	input logic                        res_valid,
	input logic                        res_ready,
	input erac_pkg::verdict_t          res_verdict,
	input logic [erac_pkg::MAC_W-1:0]  res_peer_mac,
	input logic [erac_pkg::IP_W-1:0]   res_peer_ip
);
	import erac_pkg::*;

	logic arp_verdict;

	assign arp_verdict = (res_verdict == VERDICT_ARP_REQ_REPLY) ||
		(res_verdict == VERDICT_ARP_REQ_OTHER) || (res_verdict == VERDICT_ARP_REP_UPDATE) ||
		(res_verdict == VERDICT_ARP_REP_OTHER);

	`ERAC_ASSERT(a_res_hold, (res_valid && !res_ready |=> res_valid && $stable(res_verdict) && $stable(res_peer_ip)), "result beat changed while stalled")
	`ERAC_ASSERT(a_res_from_last, ($rose(res_valid) |-> $past(rx_valid && rx_ready && rx_last_byte, 2)), "verdict without a final byte two edges earlier")
	`ERAC_ASSERT(a_peer_zero, (res_valid && !arp_verdict |-> res_peer_mac == '0 && res_peer_ip == '0), "peer fields set on a non-ARP verdict")
	`ERAC_ASSERT(a_ready_stall, (!rx_ready |-> res_valid && !res_ready), "input stalled while result side is free")
	`ERAC_ASSERT_ALWAYS(a_reset_idle, (!arst_n |=> !res_valid), "result valid right after reset")

endmodule

bind ethernet_rx_arp_classifier_top erac_checker u_erac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.rx_last_byte (rx.last_byte),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_verdict  (res.verdict),
	.res_peer_mac (res.peer_mac),
	.res_peer_ip  (res.peer_ip)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import erac_pkg::*;

	localparam int CAPTURE_BYTES = 42;
	localparam int IDLE_LIMIT    = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 4;

	// Tracks the station addresses and the header bytes of the frame in flight,
	// and queues the verdict that each final byte should produce.
	class verdict_tracker;
		bit [7:0]         hdr [CAPTURE_BYTES];
		int unsigned      count;
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
		result_t          due[$];
		int               errors;

		function new();
			count = 0;
			mac = '0;
			ip = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [MAC_W-1:0] data);
			case (idx)
				CFG_OWN_MAC: mac = data;
				CFG_OWN_IP: ip = data[IP_W-1:0];
			endcase
		endfunction

		function logic [63:0] field(int at, int n);
			logic [63:0] v;
			v = '0;
			for (int i = 0; i < n; i++)
				v = (v << 8) | hdr[at + i];
			return v;
		endfunction

		function result_t judge(int unsigned len);
			result_t     r;
			logic [63:0] w;
			logic [15:0] op;
			r = '0;
			r.verdict = VERDICT_NOT_FOR_ME;
			if (len < ETH_HDR_LEN) begin
				r.verdict = VERDICT_MALFORMED;
				return r;
			end
			w = field(OFS_DST, 6);
			if (w != mac && w != BCAST_MAC)
				return r;
			w = field(OFS_ETYPE, 2);
			if (w == ETYPE_VLAN) begin
				if (len < VLAN_END_LEN) begin
					r.verdict = VERDICT_MALFORMED;
				end else begin
					r.verdict = VERDICT_VLAN;
					w = field(OFS_W14, 2);
					r.vlan_id = w[VLAN_W-1:0];
				end
			end else if (w == ETYPE_IPV4) begin
				r.verdict = VERDICT_IPV4;
			end else if (w == ETYPE_ARP) begin
				// The ARP header is only read once the frame is long enough to hold it.
				if (len < ARP_END_LEN) begin
					r.verdict = VERDICT_MALFORMED;
					return r;
				end
				op = 16'(field(OFS_OPER, 2));
				if (field(OFS_W14, 2) != ARP_HTYPE_ETH || field(OFS_PTYPE, 2) != ETYPE_IPV4 ||
						field(OFS_HLEN, 1) != ARP_HLEN_ETH ||
						(op != ARP_OP_REQUEST && op != ARP_OP_REPLY)) begin
					r.verdict = VERDICT_MALFORMED;
					return r;
				end
				if (op == ARP_OP_REQUEST)
					r.verdict = (field(OFS_TPA, 4) == ip) ? VERDICT_ARP_REQ_REPLY
						: VERDICT_ARP_REQ_OTHER;
				else
					r.verdict = (field(OFS_TPA, 4) == ip) ? VERDICT_ARP_REP_UPDATE
						: VERDICT_ARP_REP_OTHER;
				r.peer_mac = MAC_W'(field(OFS_SHA, 6));
				r.peer_ip = IP_W'(field(OFS_SPA, 4));
			end else begin
				r.verdict = VERDICT_OTHER_DROPPED;
			end
			return r;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			int unsigned len;
			if (count < CAPTURE_BYTES)
				hdr[count] = b;
			len = (count < COUNT_MAX) ? count + 1 : COUNT_MAX;
			if (last) begin
				due.push_back(judge(len));
				count = 0;
			end else begin
				count = len;
			end
		endfunction

		function void check_verdict(verdict_t v, logic [VLAN_W-1:0] vid, logic [MAC_W-1:0] pmac,
				logic [IP_W-1:0] pip);
			result_t want;
			if (due.size() == 0) begin
				$error("verdict beat with no frame waiting: verdict %0d", v);
				errors++;
				return;
			end
			want = due.pop_front();
			if (v !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, v);
				errors++;
			end
			if (vid !== want.vlan_id) begin
				$error("vlan_id: expected %h, got %h", want.vlan_id, vid);
				errors++;
			end
			if (pmac !== want.peer_mac) begin
				$error("peer_mac: expected %h, got %h", want.peer_mac, pmac);
				errors++;
			end
			if (pip !== want.peer_ip) begin
				$error("peer_ip: expected %h, got %h", want.peer_ip, pip);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [MAC_W-1:0] cfg_data;

	erac_byte_if    rx();
	erac_verdict_if res();

	ethernet_rx_arp_classifier_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx),
		.res       (res)
	);

	always #4 clk = ~clk;

	verdict_tracker   board;
	int unsigned      quiet_cycles = 0;
	bit               hold_request = 0;
	bit               gaps_on = 0;
	int               burst_left = 0;
	logic [MAC_W-1:0] cur_mac = '0;
	logic [IP_W-1:0]  cur_ip = '0;
	logic [7:0]       frame_buf[$];

	// Monitors both channels and counts cycles in which no beat moves.
	always @(posedge clk) begin
		quiet_cycles++;
		if (arst_n) begin
			if (rx.valid && rx.ready) begin
				board.note_byte(rx.frame_byte, rx.last_byte);
				quiet_cycles = 0;
			end
			if (res.valid && res.ready) begin
				board.check_verdict(res.verdict, res.vlan_id, res.peer_mac, res.peer_ip);
				quiet_cycles = 0;
			end
		end
	end

	initial begin
		wait (quiet_cycles >= IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: switches between stall patterns, and holds off for a long
	// stretch when asked so that the block backs up into its input.
	initial begin
		int mode;
		int left;
		int tick;
		mode = 0;
		left = 0;
		tick = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(32, 256);
			end
			left--;
			tick++;
			case (mode)
				0: res.ready <= 1'b1;
				1: res.ready <= ($urandom_range(0, 1) == 1);
				2: res.ready <= ($urandom_range(0, 3) == 0);
				default: res.ready <= ((tick % 5) < 3);
			endcase
		end
	end

	function automatic logic [MAC_W-1:0] rnd48();
		return MAC_W'({$urandom, $urandom});
	endfunction

	function automatic void put(logic [63:0] v, int n);
		for (int i = n - 1; i >= 0; i--)
			frame_buf.push_back(v[8*i +: 8]);
	endfunction

	// Pads with random bytes, or cuts the frame down, to exactly len bytes.
	function automatic void pad_to(int len);
		while (frame_buf.size() < len)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		if (frame_buf.size() > len)
			frame_buf = frame_buf[0:len-1];
	endfunction

	function automatic void eth_head(logic [MAC_W-1:0] dst, logic [15:0] etype);
		frame_buf.delete();
		put(64'(dst), 6);
		put(64'(rnd48()), 6);
		put(64'(etype), 2);
	endfunction

	function automatic void arp_body(logic [15:0] op, logic [IP_W-1:0] tpa);
		put(64'(ARP_HTYPE_ETH), 2);
		put(64'(ETYPE_IPV4), 2);
		put(64'(ARP_HLEN_ETH), 1);
		// Protocol length is not checked by the block, so it varies freely.
		put(64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 4), 1);
		put(64'(op), 2);
		put(64'(rnd48()), 6);
		put(64'($urandom), 4);
		put(64'(rnd48()), 6);
		put(64'(tpa), 4);
	endfunction

	function automatic logic [MAC_W-1:0] pick_dst();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return cur_mac;
		else if (r < 8)
			return BCAST_MAC;
		return rnd48();
	endfunction

	function automatic logic [15:0] pick_op();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return ARP_OP_REQUEST;
		else if (r < 8)
			return ARP_OP_REPLY;
		return 16'($urandom_range(0, 16'hffff));
	endfunction

	function automatic void random_frame();
		int               kind;
		int               at;
		logic [MAC_W-1:0] dst;
		kind = $urandom_range(0, 99);
		dst = pick_dst();
		if (kind < 40) begin
			eth_head(dst, ETYPE_ARP);
			arp_body(pick_op(), ($urandom_range(0, 9) < 6) ? cur_ip : $urandom);
			pad_to(($urandom_range(0, 9) == 0) ? $urandom_range(43, 80)
				: ARP_END_LEN + $urandom_range(0, 4));
			if ($urandom_range(0, 6) == 0) begin
				at = $urandom_range(OFS_W14, OFS_OPER + 1);
				frame_buf[at] = frame_buf[at] ^ 8'($urandom_range(1, 255));
			end else if ($urandom_range(0, 9) == 0) begin
				pad_to($urandom_range(ETH_HDR_LEN, ARP_END_LEN - 1));
			end
		end else if (kind < 55) begin
			eth_head(dst, ETYPE_IPV4);
			pad_to($urandom_range(ETH_HDR_LEN, 70));
		end else if (kind < 67) begin
			eth_head(dst, ETYPE_VLAN);
			pad_to($urandom_range(ETH_HDR_LEN, 32));
		end else if (kind < 75) begin
			eth_head(dst, 16'($urandom_range(0, 16'hffff)));
			pad_to($urandom_range(ETH_HDR_LEN, 40));
		end else if (kind < 85) begin
			eth_head(dst, ETYPE_ARP);
			pad_to($urandom_range(1, ETH_HDR_LEN - 1));
		end else begin
			frame_buf.delete();
			pad_to($urandom_range(1, 70));
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		if (burst_left == 0) begin
			if (gaps_on) begin
				rx.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		rx.valid <= 1'b1;
		rx.frame_byte <= b;
		rx.last_byte <= last;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Lets every pending verdict come out, then lets the pipeline drain.
	task automatic finish_phase();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_station(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
		logic [MAC_W-1:0] ip_word;
		ip_word = {16'(rnd48() >> IP_W), ip};
		cfg_we <= 1'b1;
		cfg_index <= CFG_OWN_MAC;
		cfg_data <= mac;
		@(posedge clk);
		cfg_index <= CFG_OWN_IP;
		cfg_data <= ip_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(CFG_OWN_MAC, mac);
		board.set_reg(CFG_OWN_IP, ip_word);
		cur_mac = mac;
		cur_ip = ip;
	endtask

	task automatic arp_frame(logic [MAC_W-1:0] dst, logic [15:0] op, logic [IP_W-1:0] tpa,
			int len);
		eth_head(dst, ETYPE_ARP);
		arp_body(op, tpa);
		pad_to(len);
	endtask

	task automatic directed_frames();
		frame_buf = {8'hff};
		send_frame();
		eth_head(BCAST_MAC, ETYPE_IPV4);
		pad_to(ETH_HDR_LEN - 1);
		send_frame();
		eth_head(cur_mac, ETYPE_IPV4);
		send_frame();
		eth_head(BCAST_MAC, 16'h0000);
		pad_to(20);
		send_frame();
		eth_head(cur_mac ^ 48'h1, ETYPE_IPV4);
		send_frame();
		eth_head(BCAST_MAC, ETYPE_VLAN);
		pad_to(VLAN_END_LEN - 1);
		send_frame();
		eth_head(cur_mac, ETYPE_VLAN);
		put(64'(16'hffff), 2);
		put(64'(16'hffff), 2);
		send_frame();
		eth_head(BCAST_MAC, ETYPE_VLAN);
		put(64'(16'h0000), 2);
		pad_to(30);
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REQUEST, cur_ip, ARP_END_LEN - 1);
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REQUEST, cur_ip, ARP_END_LEN);
		send_frame();
		arp_frame(cur_mac, ARP_OP_REQUEST, ~cur_ip, ARP_END_LEN);
		send_frame();
		arp_frame(cur_mac, ARP_OP_REPLY, cur_ip, ARP_END_LEN + 4);
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REPLY, cur_ip ^ 32'h1, ARP_END_LEN);
		send_frame();
		// Each bad ARP header field on its own.
		arp_frame(BCAST_MAC, ARP_OP_REQUEST, cur_ip, ARP_END_LEN);
		frame_buf[OFS_W14 + 1] = 8'h02;
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REQUEST, cur_ip, ARP_END_LEN);
		frame_buf[OFS_PTYPE + 1] = 8'h06;
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REPLY, cur_ip, ARP_END_LEN);
		frame_buf[OFS_HLEN] = 8'h04;
		send_frame();
		arp_frame(cur_mac, 16'h0000, cur_ip, ARP_END_LEN);
		send_frame();
		arp_frame(cur_mac, 16'hffff, cur_ip, ARP_END_LEN);
		send_frame();
		arp_frame(cur_mac, 16'h0003, cur_ip, ARP_END_LEN);
		send_frame();
		// Unchecked protocol length, with sender fields at both extremes.
		arp_frame(BCAST_MAC, ARP_OP_REQUEST, cur_ip, ARP_END_LEN);
		frame_buf[OFS_HLEN + 1] = 8'hff;
		for (int i = OFS_SHA; i < OFS_TPA - 6; i++)
			frame_buf[i] = 8'hff;
		send_frame();
		arp_frame(BCAST_MAC, ARP_OP_REPLY, cur_ip, ARP_END_LEN);
		for (int i = OFS_SHA; i < OFS_TPA - 6; i++)
			frame_buf[i] = 8'h00;
		send_frame();
		// Lengths around the saturation of the byte count.
		eth_head(cur_mac, ETYPE_IPV4);
		pad_to(COUNT_MAX);
		send_frame();
		arp_frame(cur_mac, ARP_OP_REQUEST, cur_ip, COUNT_MAX + 1);
		send_frame();
		eth_head(BCAST_MAC, 16'hffff);
		pad_to(90);
		send_frame();
		frame_buf.delete();
		put(64'(rnd48()), 6);
		pad_to(5);
		send_frame();
		frame_buf.delete();
		put(64'(48'h0), 6);
		put(64'(48'h0), 6);
		put(64'(16'h0), 2);
		send_frame();
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OWN_MAC;
		cfg_data <= '0;
		rx.valid <= 1'b0;
		rx.frame_byte <= '0;
		rx.last_byte <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Station addresses still at their reset value.
		repeat (3) begin
			random_frame();
			send_frame();
		end
		finish_phase();

		set_station(rnd48(), $urandom);
		directed_frames();
		finish_phase();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_station(BCAST_MAC, 32'hffff_ffff);
				1: set_station('0, '0);
				2: set_station(48'h0000_0000_0001, 32'h0000_0001);
				default: set_station(rnd48(), $urandom);
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			if (p == 4) begin
				// Short frames back to back while the receiver holds off.
				gaps_on = 0;
				hold_request = 1;
				repeat (20) begin
					eth_head(pick_dst(), ETYPE_IPV4);
					pad_to($urandom_range(1, 4));
					send_frame();
				end
			end
			random_frame();
			send_frame();
			finish_phase();
		end

		if (board.due.size() != 0) begin
			$error("%0d verdicts never arrived", board.due.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
